[src/pcxrle_pkg.sv]
package pcxrle_pkg;

  localparam logic [7:0] RLE_MARK      = 8'hC0;
  localparam logic [5:0] MAX_RUN_RESET = 6'd15;

  localparam int PIXEL_W = 8;
  localparam int RUN_W   = 6;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration space
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MAX_RUN = 1'b0;

  typedef struct packed {
    logic               valid;
    logic               counted;  // run goes out as count byte + value
    logic [PIXEL_W-1:0] value;
    logic [RUN_W-1:0]   len;
  } run_t;

  // run0 is always valid; run1 holds the line-end flush that follows a broken run
  typedef struct packed {
    run_t run0;
    run_t run1;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_R0_COUNT,
    PH_R0_VALUE,
    PH_R1_COUNT,
    PH_R1_VALUE
  } phase_t;

  function automatic logic needs_count(input logic [PIXEL_W-1:0] value,
                                       input logic [RUN_W-1:0] len);
    needs_count = (len > RUN_W'(1)) || (value >= RLE_MARK);
  endfunction

  function automatic logic [PIXEL_W-1:0] count_byte(input logic [RUN_W-1:0] len);
    count_byte = RLE_MARK | PIXEL_W'(len);
  endfunction

endpackage

[src/pcxrle_front.sv]
module pcxrle_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pcxrle_pkg::RUN_W-1:0] max_run,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pcxrle_pkg::PIXEL_W-1:0] pixel,
  input  logic                         line_end,
  input  logic                         fifo_full,
  output logic                         push,
  output pcxrle_pkg::cmd_t             cmd
);
  import pcxrle_pkg::*;

  logic [PIXEL_W-1:0] held_value;
  logic [PIXEL_W-1:0] held_value_next;
  logic [RUN_W-1:0]   run_length;
  logic [RUN_W-1:0]   run_length_next;

  logic             accept;
  logic             break_run;
  logic [RUN_W-1:0] grown_len;
  run_t             broken;
  run_t             flushed;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  // A held run breaks on a new value or once it reaches the limit
  assign break_run = (run_length != '0) &&
                     ((held_value != pixel) || (run_length >= max_run));
  assign grown_len = (break_run ? RUN_W'(0) : run_length) + RUN_W'(1);

  always_comb begin
    broken.valid   = break_run;
    broken.counted = needs_count(held_value, run_length);
    broken.value   = held_value;
    broken.len     = run_length;

    flushed.valid   = line_end;
    flushed.counted = needs_count(pixel, grown_len);
    flushed.value   = pixel;
    flushed.len     = grown_len;

    cmd.run0 = break_run ? broken : flushed;
    cmd.run1 = flushed;
    cmd.run1.valid = break_run && line_end;
  end

  assign push = accept && (break_run || line_end);

  always_comb begin
    held_value_next = held_value;
    run_length_next = run_length;
    if (accept) begin
      if (line_end) begin
        held_value_next = '0;
        run_length_next = '0;
      end else begin
        held_value_next = pixel;
        run_length_next = grown_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= '0;
      run_length <= '0;
    end else begin
      held_value <= held_value_next;
      run_length <= run_length_next;
    end
  end

endmodule

[src/pcxrle_fifo.sv]
module pcxrle_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pcxrle_pkg::cmd_t push_cmd,
  input  logic             pop,
  output pcxrle_pkg::cmd_t head_cmd,
  output logic             not_empty,
  output logic             full
);
  import pcxrle_pkg::*;

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

[src/pcxrle_back.sv]
module pcxrle_back (
  input  logic                           clk,
  input  logic                           rst,
  input  pcxrle_pkg::cmd_t               head_cmd,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pcxrle_pkg::PIXEL_W-1:0] out_data,
  output logic                           out_last
);
  import pcxrle_pkg::*;

  cmd_t   cmd;
  logic   cmd_valid;
  phase_t phase;
  phase_t phase_next;

  logic [PIXEL_W-1:0] cur_byte;
  logic               cur_last;
  phase_t             step_phase;
  phase_t             start_phase;
  logic               out_free;
  logic               emit;
  logic               done;
  logic               load;

  assign out_free    = !out_valid || out_ready;
  assign emit        = cmd_valid && out_free;
  assign done        = emit && cur_last;
  assign load        = head_valid && (!cmd_valid || done);
  assign pop         = load;
  assign start_phase = head_cmd.run0.counted ? PH_R0_COUNT : PH_R0_VALUE;

  // Byte and word-end flag for the current phase
  always_comb begin
    unique case (phase)
      PH_R0_COUNT: begin
        cur_byte = count_byte(cmd.run0.len);
        cur_last = 1'b0;
      end
      PH_R0_VALUE: begin
        cur_byte = cmd.run0.value;
        cur_last = !cmd.run1.valid;
      end
      PH_R1_COUNT: begin
        cur_byte = count_byte(cmd.run1.len);
        cur_last = 1'b0;
      end
      PH_R1_VALUE: begin
        cur_byte = cmd.run1.value;
        cur_last = 1'b1;
      end
      default: begin
        cur_byte = '0;
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (phase)
      PH_R0_COUNT: step_phase = PH_R0_VALUE;
      PH_R0_VALUE: step_phase = cmd.run1.counted ? PH_R1_COUNT : PH_R1_VALUE;
      PH_R1_COUNT: step_phase = PH_R1_VALUE;
      PH_R1_VALUE: step_phase = PH_R0_COUNT;
      default:     step_phase = PH_R0_COUNT;
    endcase
    if (load) begin
      phase_next = start_phase;
    end else if (emit) begin
      phase_next = step_phase;
    end else begin
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_R0_COUNT;
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        cmd_valid <= 1'b1;
      end else if (done) begin
        cmd_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= head_cmd;
    end
    if (emit) begin
      out_data <= cur_byte;
      out_last <= cur_last;
    end
  end

endmodule

[src/pcx_scanline_rle_encoder_top.sv]
// Channel   Dir  tdata                  tuser / tlast
// s_axis    in   [7:0] pixel            tlast = line_end
// m_axis    out  [7:0] out_byte         tlast = last_of_item
// apb       cfg  0x0: max_run [5:0]     pready tied high
//
// A pixel is taken every cycle while the two-entry command queue has room.
// A pixel that closes a run yields one or two output bytes and a line end up
// to four; extending a run yields none.
// The first byte passes the command queue, the command register and out_data.
// Synchronous reset clears the held run, the queue and the output register;
// max_run returns to 15. Stalls on m_axis back up into the queue, then s_axis.
module pcx_scanline_rle_encoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcxrle_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pcxrle_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pcxrle_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import pcxrle_pkg::*;

  logic [RUN_W-1:0] max_run;
  logic             cfg_write;
  logic             reg_hit;

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic head_valid;
  logic fifo_full;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1] == REG_MAX_RUN);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_hit ? APB_DATA_W'(max_run) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run <= MAX_RUN_RESET;
    end else if (cfg_write && reg_hit) begin
      max_run <= pwdata[RUN_W-1:0];
    end
  end

  pcxrle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .max_run   (max_run),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (s_axis_tdata),
    .line_end  (s_axis_tlast),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  pcxrle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (head_valid),
    .full      (fifo_full)
  );

  pcxrle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

[src/pcxrle_checker.sv]
module pcxrle_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [7:0]                        m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [pcxrle_pkg::APB_ADDR_W-1:0] paddr,
  input logic [pcxrle_pkg::APB_DATA_W-1:0] pwdata,
  input logic [pcxrle_pkg::APB_DATA_W-1:0] prdata,
  input logic                              pready
);
  import pcxrle_pkg::*;

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  // Register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_MAX_RUN) |=>
      (paddr[APB_ADDR_W-1] != REG_MAX_RUN ||
       prdata == APB_DATA_W'($past(pwdata[RUN_W-1:0]))))
    else $error("max_run readback mismatch");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind pcx_scanline_rle_encoder_top pcxrle_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

[tb/pcx_rle_checker.sv]
module pcx_rle_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
  input  logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcxrle_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pcxrle_pkg::APB_DATA_W-1:0]   pwdata,
  input  logic [pcxrle_pkg::APB_DATA_W-1:0]   prdata,
  input  logic                                pready,
  output int                                  mismatches,
  output int                                  pending
);

  import pcxrle_pkg::*;

  localparam logic [APB_ADDR_W-1:0] MAX_RUN_ADDR = {REG_MAX_RUN, 2'b00};

  typedef struct packed {
    logic [PIXEL_W-1:0] data;
    logic               last;
  } enc_word_t;

  enc_word_t          enc_q[$];
  enc_word_t          got_word;
  enc_word_t          want_word;
  logic [RUN_W-1:0]   run_cap;
  logic [PIXEL_W-1:0] run_pixel;
  logic [RUN_W-1:0]   run_len;
  int                 fails = 0;

  function automatic void flag(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fails++;
    if (fails <= 10)
      $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Queue the held run as count+value or bare value, then clear it.
  function automatic void queue_run(input logic closes);
    if (run_len > RUN_W'(1) || run_pixel >= RLE_MARK)
      enc_q.push_back('{RLE_MARK | PIXEL_W'(run_len), 1'b0});
    enc_q.push_back('{run_pixel, closes});
    run_len = '0;
  endfunction

  function automatic void encode_pixel(input logic [PIXEL_W-1:0] pix, input logic line_end);
    if (run_len != '0 && (run_pixel != pix || run_len >= run_cap))
      queue_run(!line_end);
    run_len   = run_len + RUN_W'(1);
    run_pixel = pix;
    if (line_end) begin
      queue_run(1'b1);
      run_pixel = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      run_cap   = MAX_RUN_RESET;
      run_pixel = '0;
      run_len   = '0;
      enc_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == MAX_RUN_ADDR)
            run_cap = pwdata[RUN_W-1:0];
        end else if (prdata !== APB_DATA_W'(run_cap)) begin
          flag("max_run readback", APB_DATA_W'(run_cap), prdata);
        end
      end
      // Pop before push: a word never leaves in the cycle its pixel enters.
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = '{m_axis_tdata, m_axis_tlast};
        if (enc_q.size() == 0) begin
          flag("unexpected out word {byte,last}", '0, 32'(got_word));
        end else begin
          want_word = enc_q.pop_front();
          if (got_word !== want_word)
            flag("out word {byte,last}", 32'(want_word), 32'(got_word));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_pixel(s_axis_tdata, s_axis_tlast);
    end
    pending    <= enc_q.size();
    mismatches <= fails;
  end

endmodule

[tb/pcx_scanline_rle_encoder_top_tb.sv]
module pcx_scanline_rle_encoder_top_tb;

  import pcxrle_pkg::*;

  localparam logic [APB_ADDR_W-1:0] MAX_RUN_ADDR = {REG_MAX_RUN, 2'b00};
  localparam int STALL_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] pixel
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;   // [7:0] out_byte
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  calm = 1'b0;
  int                    mismatches;
  int                    pending;
  int                    quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcx_scanline_rle_encoder_top u_top (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pcx_rle_checker u_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches, .pending
  );

  always @(negedge clk)
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("pcx_scanline_rle_encoder_top_tb: errors");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] pix, input logic line_end);
    while (!calm && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pix;
    s_axis_tlast  = line_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the pixel stream until every predicted word has come out.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = MAX_RUN_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_max_run(input logic [RUN_W-1:0] cap, input logic noisy);
    drain();
    // let the last pixel settle inside the block before touching max_run
    repeat (8) @(negedge clk);
    apb_access(1'b1, noisy ? {26'($urandom), cap} : APB_DATA_W'(cap));
    apb_access(1'b0, '0);
  endtask

  // Scanlines with frequent repeats, a share of pixels at or above the count mark.
  task automatic stream_scanlines(input int count, input int hold_at);
    logic [7:0] pix;
    pix = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        drain();
      if ($urandom_range(0, 99) >= 45)
        pix = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(192, 255)) : 8'($urandom);
      push_pixel(pix, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset max_run: bare values, count-marked singles, runs, line-end flushes
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hBF, 1'b0);
    push_pixel(8'hC0, 1'b0);
    push_pixel(8'hFF, 1'b0);
    repeat (3) push_pixel(8'h55, 1'b0);
    push_pixel(8'h55, 1'b1);
    push_pixel(8'hAA, 1'b1);
    push_pixel(8'h12, 1'b0);
    push_pixel(8'h34, 1'b1);
    push_pixel(8'hE0, 1'b0);
    push_pixel(8'hE0, 1'b0);
    push_pixel(8'hF0, 1'b1);

    // run at limit: equal pixel past max_run starts a new run
    set_max_run(6'd2, 1'b0);
    repeat (3) push_pixel(8'h77, 1'b0);
    push_pixel(8'h77, 1'b1);

    // zero max_run behaves as one
    set_max_run(6'd0, 1'b1);
    push_pixel(8'h09, 1'b0);
    push_pixel(8'h09, 1'b1);

    set_max_run(6'd63, 1'b1);
    for (int i = 0; i < 66; i++)
      push_pixel(8'hC5, i == 65);
    stream_scanlines(30, -1);

    set_max_run(6'd1, 1'b0);
    stream_scanlines(40, -1);

    calm = 1'b1;
    set_max_run(6'($urandom_range(2, 8)), 1'b1);
    stream_scanlines(50, 25);
    calm = 1'b0;

    set_max_run(6'd15, 1'b0);
    stream_scanlines(60, -1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("pcx_scanline_rle_encoder_top_tb: clean");
    else
      $display("pcx_scanline_rle_encoder_top_tb: errors");
    $finish;
  end

endmodule
